// ----- design/qts_pkg.sv -----
// Shared types, character codes and helpers for the quoted token splitter.
package qts_pkg;

    // Character codes
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NEL    = 8'h85;
    localparam logic [7:0] CH_NBSP   = 8'hA0;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Depth of the result buffer
    localparam int OUT_DEPTH = 2;

    // Parser flags
    typedef struct packed {
        logic inside_quote;
        logic quote_is_single;
        logic escape_pending;
        logic skipping_comment;
        logic token_nonempty;
    } state_t;

    // One result word
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       token_end;
        logic       line_done;
    } result_t;

    // Result handed from the step logic to the output buffer
    typedef struct packed {
        logic    push;
        result_t res;
    } res_push_t;

    // Whitespace outside quotes
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)) ||
               (c == CH_NEL) || (c == CH_NBSP);
    endfunction

endpackage

// ----- design/qts_if.sv -----
// Handshake interfaces for the input character words and the result words.
interface qts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       line_end;

    modport source (output valid, output char_code, output line_end, input ready);
    modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface qts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_end;
    logic       line_done;

    modport source (output valid, output out_char, output char_valid,
                    output token_end, output line_done, input ready);
    modport sink   (input valid, input out_char, input char_valid,
                    input token_end, input line_done, output ready);
endinterface

// ----- design/qts_step.sv -----
// Tokenizer flags and the per-character decision logic.
module qts_step
    import qts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] char_code,
    input  logic       line_end,
    output res_push_t  res_push
);

    state_t state_reg;
    state_t state_next;
    res_push_t rp;
    logic [7:0] q_char;
    logic [7:0] esc_char;

    // Flag register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

    assign q_char = state_reg.quote_is_single ? CH_SQUOTE : CH_DQUOTE;

    // Escape translation
    always_comb
    begin
        esc_char = char_code;
        if (char_code == CH_N)
        begin
            esc_char = CH_NL;
        end
        else if (char_code == CH_T)
        begin
            esc_char = CH_TAB;
        end
    end

    // Next flags and result for the word on the input
    always_comb
    begin
        state_next = state_reg;
        rp         = '0;
        if (line_end)
        begin
            rp.push           = 1'b1;
            rp.res.line_done  = 1'b1;
            if (state_reg.escape_pending)
            begin
                rp.res.out_char   = CH_BSLASH;
                rp.res.char_valid = 1'b1;
                rp.res.token_end  = 1'b1;
            end
            else
            begin
                rp.res.token_end  = state_reg.token_nonempty;
            end
            state_next = '0;
        end
        else if (state_reg.skipping_comment)
        begin
            // rest of line ignored
        end
        else if (state_reg.inside_quote)
        begin
            if (state_reg.escape_pending)
            begin
                state_next.escape_pending = 1'b0;
                state_next.token_nonempty = 1'b1;
                rp.push           = 1'b1;
                rp.res.out_char   = esc_char;
                rp.res.char_valid = 1'b1;
            end
            else if (char_code == q_char)
            begin
                state_next.inside_quote    = 1'b0;
                state_next.quote_is_single = 1'b0;
                state_next.token_nonempty  = 1'b0;
                rp.push          = state_reg.token_nonempty;
                rp.res.token_end = state_reg.token_nonempty;
            end
            else if (char_code == CH_BSLASH)
            begin
                state_next.escape_pending = 1'b1;
            end
            else
            begin
                state_next.token_nonempty = 1'b1;
                rp.push           = 1'b1;
                rp.res.out_char   = char_code;
                rp.res.char_valid = 1'b1;
            end
        end
        else if ((char_code == CH_DQUOTE) || (char_code == CH_SQUOTE))
        begin
            state_next.inside_quote    = 1'b1;
            state_next.quote_is_single = (char_code == CH_SQUOTE);
        end
        else if (is_blank(char_code))
        begin
            state_next.token_nonempty = 1'b0;
            rp.push          = state_reg.token_nonempty;
            rp.res.token_end = state_reg.token_nonempty;
        end
        else if ((char_code == CH_HASH) || (char_code == CH_SEMI))
        begin
            state_next.skipping_comment = 1'b1;
        end
        else
        begin
            state_next.token_nonempty = 1'b1;
            rp.push           = 1'b1;
            rp.res.out_char   = char_code;
            rp.res.char_valid = 1'b1;
        end
    end

    assign res_push.push = rp.push & take;
    assign res_push.res  = rp.res;

endmodule

// ----- design/qts_out_buf.sv -----
// Two-entry result buffer between the step logic and the output channel.
module qts_out_buf
    import qts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  res_push_t  res_push,
    output logic       space,
    qts_out_if.source  out_ch
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    result_t              mem_reg [OUT_DEPTH];
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 pop;
    result_t              head;

    assign pop   = (count_reg != '0) && out_ch.ready;
    assign space = (count_reg != CNT_W'(OUT_DEPTH));

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (res_push.push)
        begin
            mem_reg[wr_ptr_reg] <= res_push.res;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (res_push.push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(res_push.push) - CNT_W'(pop);
        end
    end

    // Output word
    assign head              = mem_reg[rd_ptr_reg];
    assign out_ch.valid      = (count_reg != '0);
    assign out_ch.out_char   = head.out_char;
    assign out_ch.char_valid = head.char_valid;
    assign out_ch.token_end  = head.token_end;
    assign out_ch.line_done  = head.line_done;

endmodule

// ----- design/quoted_token_splitter_top.sv -----
// Top level of the quoted token splitter: step logic feeding a result buffer.
//
//   channel   dir   word contents
//   in_ch     in    char_code[7:0], line_end
//   out_ch    out   out_char[7:0], char_valid, token_end, line_done
//
// One input word is taken per cycle while there is space; its result (if any)
// goes into a two-entry buffer and shows on out_ch once it reaches its head.
// in_ch.ready drops only when both buffer entries hold untaken results.
// Reset clears the tokenizer flags and empties the buffer.
module quoted_token_splitter_top
    import qts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    qts_in_if.sink    in_ch,
    qts_out_if.source out_ch
);

    logic      take;
    logic      space;
    res_push_t res_push;

    assign in_ch.ready = space;
    assign take        = in_ch.valid & space;

    qts_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .char_code (in_ch.char_code),
        .line_end  (in_ch.line_end),
        .res_push  (res_push)
    );

    qts_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .space    (space),
        .out_ch   (out_ch)
    );

endmodule
